/* sv/ntc_adc_to_temperature_core_macros.svh */
// Assertion macros used by the thermistor converter checker.
`ifndef NTC_ADC_TO_TEMPERATURE_CORE_MACROS_SVH
`define NTC_ADC_TO_TEMPERATURE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, held off while rst_n is low
`define NTC_A2T_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, held off while rst_n is low
`define NTC_A2T_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ntc_a2t_pkg.sv */
// Shared constants and types for the thermistor ADC to temperature converter.
`timescale 1ns / 1ps
package ntc_a2t_pkg;

  // Default sizes
  localparam int TABLE_SIZE_DEF  = 141;
  localparam int SAMPLE_BITS_DEF = 12;

  // Fixed field widths
  localparam int INDEX_BITS = 8;
  localparam int TEMP_BITS  = 11;

  // Interpolation fraction: hundredths of a degree, 0..100
  localparam int FRAC_BITS = 7;
  localparam logic [FRAC_BITS-1:0] FRAC_FULL = FRAC_BITS'(100);
  localparam int KW = $clog2(FRAC_BITS);

  // Tenths per table step, and reciprocal of ten for the fraction
  localparam int DEG_TENTHS  = 10;
  localparam int RECIP_TEN   = 205;
  localparam int RECIP_SHIFT = 11;
  localparam int RECIP_W     = FRAC_BITS + 8;

  // Result ceiling
  localparam int TEMP_MAX = 2047;

  // Operation codes
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_CHK_LO,
    S_CHK_HI,
    S_SEARCH,
    S_T_LO,
    S_T_HI,
    S_SPAN_NEG,
    S_DIFF_POS,
    S_DIFF_NEG,
    S_CLAMP,
    S_DIV,
    S_DONE
  } state_t;

endpackage

/* sv/ntc_adc_to_temperature_core.sv */
// Thermistor ADC sample to temperature converter: sequencer and top level.
`timescale 1ns / 1ps
// Converts a thermistor ADC sample to temperature in tenths of a degree by binary search
// over a calibration table of one entry per degree, then linear interpolation. Table
// entries are loaded through the same input channel (op write); a write beat gives no
// result, and every entry a conversion reads must have been written first. A conversion
// beat holds in_stall high until its result is loaded into the output register: the
// first and last entries are read and the sample is checked against them, which ends an
// out-of-range sample; otherwise a binary search finds the bracketing pair, which is
// fetched to form span and offset, then a restoring division forms the fraction (skipped
// when the fraction saturates or the span is zero), and the result waits until an earlier
// result still stalled in the output register has been taken.
// The rate is set by the single subtract/compare unit that most steps share and by the
// one read per cycle of the table memory. A finished result waits in the output register
// while the next beat is taken.
module ntc_adc_to_temperature_core #(
  parameter int TABLE_SIZE  = ntc_a2t_pkg::TABLE_SIZE_DEF,
  parameter int SAMPLE_BITS = ntc_a2t_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [ntc_a2t_pkg::INDEX_BITS-1:0]  in_entry_index,
  input  logic [SAMPLE_BITS-1:0]              in_entry_value,
  input  logic [SAMPLE_BITS-1:0]              in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ntc_a2t_pkg::TEMP_BITS-1:0]   out_temp_tenths,
  output logic                                out_out_of_range
);

  import ntc_a2t_pkg::*;

  localparam int IW = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;
  localparam int AW = SAMPLE_BITS + FRAC_BITS;
  localparam int TW = IW + TEMP_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);

  // Control state
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Payload and working registers
  logic [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic [SAMPLE_BITS-1:0] first_r, first_nxt;
  logic [SAMPLE_BITS-1:0] last_r, last_nxt;
  logic                   rising_r, rising_nxt;
  logic [IW-1:0]          lo_r, lo_nxt;
  logic [IW-1:0]          hi_r, hi_nxt;
  logic [IW-1:0]          mid_r, mid_nxt;
  logic [SAMPLE_BITS-1:0] tlo_r, tlo_nxt;
  logic [SAMPLE_BITS-1:0] thi_r, thi_nxt;
  logic [SAMPLE_BITS-1:0] span_r, span_nxt;
  logic [SAMPLE_BITS-1:0] diff_r, diff_nxt;
  logic [AW-1:0]          num_r, num_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic [FRAC_BITS-1:0]   frac_r, frac_nxt;
  logic                   oor_r, oor_nxt;
  logic [TEMP_BITS-1:0]   out_temp_r, out_temp_nxt;
  logic                   out_oor_r, out_oor_nxt;

  // Table and shared unit connections
  logic                   wr_en;
  logic                   rd_en;
  logic [IW-1:0]          rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [AW-1:0]          alu_a, alu_b, alu_diff;
  logic                   alu_ge;

  // Search bounds and probe
  logic [IW-1:0] sel_lo, sel_hi, sel_mid;
  logic [IW:0]   gap, bound_sum;
  logic          gap_gt1;

  // Result formation
  logic [RECIP_W-1:0] frac_scaled;
  logic [TW-1:0]      temp_full;
  logic [TEMP_BITS-1:0] temp_sat;

  logic accept, out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign wr_en     = accept && (in_op == OP_WRITE) &&
                     ({1'b0, in_entry_index} < (INDEX_BITS + 1)'(TABLE_SIZE));

  ntc_a2t_tbl #(
    .DEPTH (TABLE_SIZE),
    .AW    (IW),
    .DW    (SAMPLE_BITS)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_entry_index[IW-1:0]),
    .wr_data (in_entry_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ntc_a2t_alu #(
    .W (AW)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  // Pick the shared unit's operands for this step
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_r)
      S_LAST: begin
        alu_a = AW'(first_r);
        alu_b = AW'(rd_data);
      end
      S_CHK_LO: begin
        alu_a = AW'(x_r);
        alu_b = rising_r ? AW'(first_r) : AW'(last_r);
      end
      S_CHK_HI: begin
        alu_a = rising_r ? AW'(last_r) : AW'(first_r);
        alu_b = AW'(x_r);
      end
      S_SEARCH: begin
        alu_a = rising_r ? AW'(x_r) : AW'(rd_data);
        alu_b = rising_r ? AW'(rd_data) : AW'(x_r);
      end
      S_T_HI: begin
        alu_a = AW'(rd_data);
        alu_b = AW'(tlo_r);
      end
      S_SPAN_NEG: begin
        alu_a = AW'(tlo_r);
        alu_b = AW'(thi_r);
      end
      S_DIFF_POS: begin
        alu_a = AW'(x_r);
        alu_b = AW'(tlo_r);
      end
      S_DIFF_NEG: begin
        alu_a = AW'(tlo_r);
        alu_b = AW'(x_r);
      end
      S_CLAMP: begin
        alu_a = AW'(diff_r);
        alu_b = AW'(span_r);
      end
      S_DIV: begin
        alu_a = num_r;
        alu_b = AW'(span_r) << k_r;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  // Narrow the search bracket; a probe at or before the sample in table order keeps the upper half
  always_comb begin
    if (state_r == S_SEARCH) begin
      sel_lo = alu_ge ? mid_r : lo_r;
      sel_hi = alu_ge ? hi_r : mid_r;
    end else begin
      sel_lo = '0;
      sel_hi = LAST_IDX;
    end
    gap       = {1'b0, sel_hi} - {1'b0, sel_lo};
    gap_gt1   = (gap > (IW + 1)'(1));
    bound_sum = {1'b0, sel_lo} + {1'b0, sel_hi};
    sel_mid   = bound_sum[IW:1];
  end

  // Form the result: lo*10 + frac/10, saturated, or zero when out of range
  always_comb begin
    frac_scaled = RECIP_W'(frac_r) * RECIP_W'(RECIP_TEN);
    temp_full   = TW'(lo_r) * TW'(DEG_TENTHS) + TW'(frac_scaled[RECIP_W-1:RECIP_SHIFT]);
    if (oor_r) begin
      temp_sat = '0;
    end else if (temp_full > TW'(TEMP_MAX)) begin
      temp_sat = TEMP_BITS'(TEMP_MAX);
    end else begin
      temp_sat = temp_full[TEMP_BITS-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_op == OP_CONVERT)) begin
          state_nxt = S_FIRST;
        end
      end
      S_FIRST:  state_nxt = S_LAST;
      S_LAST:   state_nxt = S_CHK_LO;
      S_CHK_LO: state_nxt = alu_ge ? S_CHK_HI : S_DONE;
      S_CHK_HI: begin
        if (!alu_ge) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = gap_gt1 ? S_SEARCH : S_T_LO;
        end
      end
      S_SEARCH:   state_nxt = gap_gt1 ? S_SEARCH : S_T_LO;
      S_T_LO:     state_nxt = S_T_HI;
      S_T_HI:     state_nxt = alu_ge ? S_DIFF_POS : S_SPAN_NEG;
      S_SPAN_NEG: state_nxt = S_DIFF_POS;
      S_DIFF_POS: state_nxt = alu_ge ? S_CLAMP : S_DIFF_NEG;
      S_DIFF_NEG: state_nxt = S_CLAMP;
      S_CLAMP: begin
        if ((span_r == '0) || alu_ge) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (k_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath updates and table reads
  always_comb begin
    x_nxt        = x_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    rising_nxt   = rising_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    tlo_nxt      = tlo_r;
    thi_nxt      = thi_r;
    span_nxt     = span_r;
    diff_nxt     = diff_r;
    num_nxt      = num_r;
    k_nxt        = k_r;
    frac_nxt     = frac_r;
    oor_nxt      = oor_r;
    out_temp_nxt = out_temp_r;
    out_oor_nxt  = out_oor_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en        = 1'b0;
    rd_addr      = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_op == OP_CONVERT)) begin
          x_nxt    = in_sample;
          oor_nxt  = 1'b0;
          frac_nxt = '0;
          lo_nxt   = '0;
          rd_en    = 1'b1;
          rd_addr  = '0;
        end
      end
      S_FIRST: begin
        first_nxt = rd_data;
        rd_en     = 1'b1;
        rd_addr   = LAST_IDX;
      end
      S_LAST: begin
        last_nxt   = rd_data;
        rising_nxt = !alu_ge;
      end
      S_CHK_LO: begin
        if (!alu_ge) begin
          oor_nxt = 1'b1;
        end
      end
      S_CHK_HI, S_SEARCH: begin
        if ((state_r == S_CHK_HI) && !alu_ge) begin
          oor_nxt = 1'b1;
        end else begin
          lo_nxt  = sel_lo;
          hi_nxt  = sel_hi;
          rd_en   = 1'b1;
          if (gap_gt1) begin
            mid_nxt = sel_mid;
            rd_addr = sel_mid;
          end else begin
            rd_addr = sel_lo;
          end
        end
      end
      S_T_LO: begin
        tlo_nxt = rd_data;
        rd_en   = 1'b1;
        rd_addr = lo_r + IW'(1);
      end
      S_T_HI: begin
        thi_nxt  = rd_data;
        span_nxt = alu_diff[SAMPLE_BITS-1:0];
      end
      S_SPAN_NEG: begin
        span_nxt = alu_diff[SAMPLE_BITS-1:0];
      end
      S_DIFF_POS, S_DIFF_NEG: begin
        diff_nxt = alu_diff[SAMPLE_BITS-1:0];
      end
      S_CLAMP: begin
        if (span_r == '0) begin
          frac_nxt = '0;
        end else if (alu_ge) begin
          frac_nxt = FRAC_FULL;
        end else begin
          num_nxt  = AW'(diff_r) * AW'(FRAC_FULL);
          k_nxt    = KW'(FRAC_BITS - 1);
          frac_nxt = '0;
        end
      end
      S_DIV: begin
        // Restoring step: subtract the shifted span where it fits
        if (alu_ge) begin
          num_nxt  = alu_diff;
          frac_nxt = frac_r | (FRAC_BITS'(1) << k_r);
        end
        k_nxt = k_r - KW'(1);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = temp_sat;
          out_oor_nxt   = oor_r;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    rising_r   <= rising_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    tlo_r      <= tlo_nxt;
    thi_r      <= thi_nxt;
    span_r     <= span_nxt;
    diff_r     <= diff_nxt;
    num_r      <= num_nxt;
    k_r        <= k_nxt;
    frac_r     <= frac_nxt;
    oor_r      <= oor_nxt;
    out_temp_r <= out_temp_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_temp_tenths  = out_temp_r;
  assign out_out_of_range = out_oor_r;

endmodule

/* sv/ntc_a2t_tbl.sv */
// Calibration table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ntc_a2t_tbl #(
  parameter int DEPTH = 141,
  parameter int AW    = 8,
  parameter int DW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Store a write beat, register the read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/ntc_a2t_alu.sv */
// Shared subtract and compare unit used by most steps of a conversion.
`timescale 1ns / 1ps
module ntc_a2t_alu #(
  parameter int W = 19
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic borrow;

  // One subtractor: difference and a >= b from the borrow
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ge = ~borrow;

endmodule

/* sv/ntc_a2t_chk.sv */
// Port-level checker for the thermistor converter, bound to the top level.
`timescale 1ns / 1ps
`include "ntc_adc_to_temperature_core_macros.svh"
module ntc_a2t_chk #(
  parameter int TABLE_SIZE  = ntc_a2t_pkg::TABLE_SIZE_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               in_op,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [ntc_a2t_pkg::TEMP_BITS-1:0]  out_temp_tenths,
  input logic                               out_out_of_range
);

  import ntc_a2t_pkg::*;

  localparam int TOP_T = ((TABLE_SIZE - 1) * DEG_TENTHS > TEMP_MAX) ?
                         TEMP_MAX : (TABLE_SIZE - 1) * DEG_TENTHS;
  localparam logic [TEMP_BITS-1:0] MAX_T = TEMP_BITS'(TOP_T);

  logic in_beat, conv_beat;

  assign in_beat   = in_valid && !in_stall;
  assign conv_beat = in_beat && (in_op == OP_CONVERT);

  // Hold a stalled result beat
  `NTC_A2T_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_temp_tenths) && $stable(out_out_of_range), "stalled result changed")

  // Out-of-range results carry zero
  `NTC_A2T_ASSERT_NOW(a_oor_zero, out_valid && out_out_of_range, out_temp_tenths == '0, "out-of-range result not zero")

  // Results stay within the table span
  `NTC_A2T_ASSERT_NOW(a_temp_max, out_valid, out_temp_tenths <= MAX_T, "temperature beyond table span")

  // A conversion beat makes the block busy
  `NTC_A2T_ASSERT_NEXT(a_conv_busy, conv_beat, in_stall, "conversion did not stall the input")

  // No result appears straight after an accepted beat
  `NTC_A2T_ASSERT_NEXT(a_no_early, in_beat, !$rose(out_valid), "result raised too early")

endmodule

bind ntc_adc_to_temperature_core ntc_a2t_chk #(
  .TABLE_SIZE  (TABLE_SIZE)
) u_ntc_a2t_chk (.*);

/* dv/tb_top.sv */
// Self-checking testbench for the thermistor ADC to temperature converter.
`timescale 1ns / 1ps
module tb_top;
  import ntc_a2t_pkg::*;

  localparam int TBL_N          = TABLE_SIZE_DEF;
  localparam int SBITS          = SAMPLE_BITS_DEF;
  localparam int SMAX           = (1 << SBITS) - 1;
  localparam int IDX_MAX        = (1 << INDEX_BITS) - 1;
  localparam int FRAC_SCALE     = 100;
  localparam int MAX_GAP        = 19;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;

  typedef enum int {
    SHAPE_FULL,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_PLATEAU,
    SHAPE_SCATTER,
    SHAPE_FLAT
  } tbl_shape_t;

  typedef struct packed {
    logic [TEMP_BITS-1:0] tenths;
    logic                 oor;
  } temp_reading_t;

  // Mirror of the calibration table and the readings still owed by the block
  class temp_scoreboard;
    logic [SBITS-1:0] cal_tbl [TBL_N];
    temp_reading_t    expected_temps [$];
    int mismatches, writes, conversions, flagged;

    // Search for the bracketing pair, then interpolate in hundredths of a degree
    function temp_reading_t interpolate_temp(logic [SBITS-1:0] x);
      int unsigned first, last, lo, hi, mid, span, offs, frac, tenths;
      bit rising, keep_lower;
      temp_reading_t r;
      first  = cal_tbl[0];
      last   = cal_tbl[TBL_N-1];
      rising = first < last;
      r.oor  = rising ? (x < first || x > last) : (x > first || x < last);
      if (r.oor) begin
        r.tenths = '0;
        return r;
      end
      lo = 0;
      hi = TBL_N - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) >> 1;
        keep_lower = rising ? (x < cal_tbl[mid]) : (x > cal_tbl[mid]);
        if (keep_lower) hi = mid;
        else lo = mid;
      end
      span = (cal_tbl[lo+1] >= cal_tbl[lo]) ? cal_tbl[lo+1] - cal_tbl[lo]
                                             : cal_tbl[lo] - cal_tbl[lo+1];
      offs = (x >= cal_tbl[lo]) ? x - cal_tbl[lo] : cal_tbl[lo] - x;
      frac = (span == 0) ? 0 : offs * FRAC_SCALE / span;
      if (frac > FRAC_SCALE) frac = FRAC_SCALE;
      tenths = (lo * FRAC_SCALE + frac) / DEG_TENTHS;
      if (tenths > TEMP_MAX) tenths = TEMP_MAX;
      r.tenths = TEMP_BITS'(tenths);
      return r;
    endfunction

    function void note_beat(logic op, logic [INDEX_BITS-1:0] idx,
                            logic [SBITS-1:0] val, logic [SBITS-1:0] smp);
      if (op == OP_WRITE) begin
        writes++;
        if (idx < TBL_N) cal_tbl[idx] = val;
      end else begin
        conversions++;
        expected_temps.push_back(interpolate_temp(smp));
      end
    endfunction

    function void check_reading(logic [TEMP_BITS-1:0] tenths, logic oor);
      temp_reading_t want;
      if (oor === 1'b1) flagged++;
      if (expected_temps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb_top: reading %0d/%0b with nothing pending", tenths, oor);
        return;
      end
      want = expected_temps.pop_front();
      if (tenths !== want.tenths || oor !== want.oor) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb_top: mismatch: expected tenths %0d oor %0b, got tenths %0d oor %0b",
                   want.tenths, want.oor, tenths, oor);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_op;
  logic [INDEX_BITS-1:0] in_entry_index;
  logic [SBITS-1:0]      in_entry_value;
  logic [SBITS-1:0]      in_sample;
  logic                  out_valid;
  logic                  out_stall;
  logic [TEMP_BITS-1:0]  out_temp_tenths;
  logic                  out_out_of_range;

  temp_scoreboard sb;
  bit burst;
  bit hold_out_long;
  int idle_cycles = 0;

  ntc_adc_to_temperature_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_temp_tenths  (out_temp_tenths),
    .out_out_of_range (out_out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one beat after a random gap (none in burst mode) and hold it until taken
  task automatic send_beat(logic op, int idx, int val, int smp);
    int gap;
    gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_entry_index <= INDEX_BITS'(idx);
    in_entry_value <= SBITS'(val);
    in_sample      <= SBITS'(smp);
    do @(posedge clk); while (in_stall);
    sb.note_beat(op, INDEX_BITS'(idx), SBITS'(val), SBITS'(smp));
  endtask

  task automatic write_entry(int idx, int val);
    send_beat(OP_WRITE, idx, val, $urandom_range(0, SMAX));
  endtask

  task automatic convert_sample(int smp);
    send_beat(OP_CONVERT, $urandom_range(0, IDX_MAX), $urandom_range(0, SMAX), smp);
  endtask

  // Drop valid and wait for every owed reading
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_temps.size() != 0);
  endtask

  // Fill every table entry, with the odd out-of-range write mixed in
  task automatic load_table(tbl_shape_t shape);
    logic [SBITS-1:0] vals [TBL_N];
    int acc, step, level;
    acc   = $urandom_range(0, 200);
    level = $urandom_range(0, SMAX);
    for (int i = 0; i < TBL_N; i++) begin
      case (shape)
        SHAPE_FULL:    vals[i] = SBITS'(i * SMAX / (TBL_N - 1));
        SHAPE_SCATTER: vals[i] = SBITS'($urandom_range(0, SMAX));
        SHAPE_FLAT:    vals[i] = SBITS'(level);
        default: begin
          if (shape == SHAPE_PLATEAU)
            step = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 27) : 0;
          else
            step = $urandom_range(0, 27);
          if (shape == SHAPE_FALLING) vals[TBL_N-1-i] = SBITS'(acc);
          else vals[i] = SBITS'(acc);
          acc += step;
        end
      endcase
    end
    for (int i = 0; i < TBL_N; i++) begin
      if ($urandom_range(0, 15) == 0)
        write_entry($urandom_range(TBL_N, IDX_MAX), $urandom_range(0, SMAX));
      write_entry(i, vals[i]);
    end
  endtask

  // Mostly samples within the span, some on or beside an entry, some anywhere or at the edges
  function automatic int pick_sample();
    int lo_v, hi_v, r, v;
    lo_v = (sb.cal_tbl[0] < sb.cal_tbl[TBL_N-1]) ? sb.cal_tbl[0] : sb.cal_tbl[TBL_N-1];
    hi_v = (sb.cal_tbl[0] < sb.cal_tbl[TBL_N-1]) ? sb.cal_tbl[TBL_N-1] : sb.cal_tbl[0];
    r = $urandom_range(0, 99);
    if (r < 70) v = $urandom_range(hi_v, lo_v);
    else if (r < 85) v = sb.cal_tbl[$urandom_range(0, TBL_N-1)] + $urandom_range(0, 2) - 1;
    else if (r < 95) v = $urandom_range(0, SMAX);
    else begin
      case ($urandom_range(0, 3))
        0:       v = 0;
        1:       v = SMAX;
        2:       v = lo_v - 1;
        default: v = hi_v + 1;
      endcase
    end
    if (v < 0) v = 0;
    if (v > SMAX) v = SMAX;
    return v;
  endfunction

  task automatic random_mix(int n, bit keep_busy);
    int done_items, r, idx, val;
    done_items = 0;
    if (keep_busy) burst = 1'b1;
    while (done_items < n) begin
      if (!keep_busy && done_items % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 75) begin
        convert_sample(pick_sample());
        done_items++;
      end else if (r < 90) begin
        // Rewrite one entry, half the time between its neighbours
        idx = $urandom_range(0, TBL_N-1);
        if (idx > 0 && idx < TBL_N-1 && $urandom_range(0, 1) == 1)
          val = $urandom_range(sb.cal_tbl[idx-1], sb.cal_tbl[idx+1]);
        else
          val = $urandom_range(0, SMAX);
        write_entry(idx, val);
        done_items++;
      end else begin
        write_entry($urandom_range(TBL_N, IDX_MAX), $urandom_range(0, SMAX));
      end
    end
    burst = 1'b0;
  endtask

  // Result side: random stalls, one long hold on request
  initial begin : result_sink
    int n;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_out_long) begin
        n = LONG_HOLD;
        hold_out_long = 1'b0;
      end else begin
        n = burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_reading(out_temp_tenths, out_out_of_range);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: watchdog, no beat for %0d cycles", idle_cycles);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    tbl_shape_t shapes [5];
    int t69, t70;
    shapes = '{SHAPE_RISING, SHAPE_FALLING, SHAPE_PLATEAU, SHAPE_SCATTER, SHAPE_FLAT};
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_WRITE;
    in_entry_index = '0;
    in_entry_value = '0;
    in_sample      = '0;
    out_stall      = 1'b0;
    burst          = 1'b0;
    hold_out_long  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full-swing table, end points, ignored writes, odd shapes of the ends
    load_table(SHAPE_FULL);
    t69 = sb.cal_tbl[69];
    t70 = sb.cal_tbl[70];
    convert_sample(0);
    convert_sample(SMAX);
    convert_sample(SMAX / 2);
    convert_sample(t70);
    convert_sample(t70 + 1);
    write_entry(IDX_MAX, SMAX);
    write_entry(TBL_N, 0);
    convert_sample(SMAX);
    // zero span between two neighbours
    write_entry(70, t69);
    convert_sample(t69);
    convert_sample(t69 + 1);
    // below and above the span
    write_entry(0, 100);
    convert_sample(50);
    convert_sample(100);
    write_entry(TBL_N-1, 4000);
    convert_sample(SMAX);
    convert_sample(4000);
    // falling ends over a rising interior
    write_entry(0, SMAX);
    write_entry(TBL_N-1, 0);
    convert_sample(SMAX);
    convert_sample(0);
    convert_sample(1000);
    // equal ends: only that one count is in range
    write_entry(0, 2000);
    write_entry(TBL_N-1, 2000);
    convert_sample(2000);
    convert_sample(1999);
    convert_sample(2001);
    drain();

    // Random phases, one table shape each; the falling one runs against a long hold
    foreach (shapes[k]) begin
      load_table(shapes[k]);
      if (shapes[k] == SHAPE_FALLING) hold_out_long = 1'b1;
      random_mix((shapes[k] == SHAPE_FLAT) ? 30 : 100, shapes[k] == SHAPE_FALLING);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb_top: %0d table writes and %0d conversions over six table shapes",
             sb.writes, sb.conversions);
    $display("tb_top: %0d readings flagged out of range, %0d mismatches, %0d owed",
             sb.flagged, sb.mismatches, sb.expected_temps.size());
    if (sb.mismatches == 0 && sb.expected_temps.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/ntc_a2t_pkg.sv
sv/ntc_a2t_tbl.sv
sv/ntc_a2t_alu.sv
sv/ntc_adc_to_temperature_core.sv
sv/ntc_a2t_chk.sv
dv/tb_top.sv
